// File: design/mts_pkg.sv
// mts_pkg: shared types and constants of the min tracking stack
// depends on nothing; used by mts_cell, mts_lifo and min_tracking_stack_unit
package mts_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned DataW      = 32;
  localparam int unsigned CntW       = $clog2(StackDepth + 1);

  typedef logic [DataW-1:0] word_t;
  typedef logic [CntW-1:0]  cnt_t;

  typedef enum logic [0:0] {
    OpPush = 1'b0,
    OpPop  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StUnderflow = 2'd1,
    StOverflow  = 2'd2
  } status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

// File: design/mts_cell.sv
// mts_cell: one storage cell of the shifting stack row
// depends on mts_pkg for the word and shift control types
module mts_cell (
  input  logic           clk_i,
  input  mts_pkg::shift_t shift_i,
  input  mts_pkg::word_t  above_i,
  input  mts_pkg::word_t  below_i,
  output mts_pkg::word_t  word_o
);

  mts_pkg::word_t word_q;
  mts_pkg::word_t word_d;

  always_comb begin
    word_d = word_q;
    if (shift_i.push) begin
      word_d = above_i;
    end else if (shift_i.pop) begin
      word_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// File: design/mts_lifo.sv
// mts_lifo: row of mts_cell with the top at cell 0, plus the fill count
// depends on mts_pkg and mts_cell
module mts_lifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mts_pkg::shift_t shift_i,
  input  mts_pkg::word_t  data_i,
  output mts_pkg::word_t  top_o,
  output mts_pkg::word_t  next_o,
  output mts_pkg::cnt_t   count_o
);

  mts_pkg::word_t cell_word [mts_pkg::StackDepth];
  mts_pkg::cnt_t  count_q;
  mts_pkg::cnt_t  count_d;

  for (genvar i = 0; i < mts_pkg::StackDepth; i++) begin : g_cell
    mts_pkg::word_t above;
    mts_pkg::word_t below;
    if (i == 0) begin : g_top
      assign above = data_i;
    end else begin : g_mid
      assign above = cell_word[i-1];
    end
    if (i == mts_pkg::StackDepth - 1) begin : g_bot
      assign below = cell_word[i];
    end else begin : g_inner
      assign below = cell_word[i+1];
    end
    mts_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_i),
      .above_i (above),
      .below_i (below),
      .word_o  (cell_word[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (shift_i.push) begin
      count_d = count_q + mts_pkg::CntW'(1);
    end else if (shift_i.pop) begin
      count_d = count_q - mts_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign top_o   = cell_word[0];
  assign next_o  = cell_word[1];
  assign count_o = count_q;

endmodule

// File: design/min_tracking_stack_unit.sv
// min_tracking_stack_unit: stack of signed words that also reports its minimum
// depends on mts_pkg and mts_lifo (word row and minimum row of shifting cells)
// result word is registered and valid in the cycle after the input is accepted
// throughput: one word per cycle barring output stall; rows shift at most once
// reset clears both fill counts and the result valid; cell contents are not reset
module min_tracking_stack_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] popped_value_o,
  output logic [31:0] min_value_o,
  output logic        is_empty_o,
  output logic [1:0]  status_o
);

  logic            accept;
  logic            is_pop;
  logic            w_empty;
  logic            w_full;
  logic            m_empty;
  logic            m_full;
  logic            m_le;
  mts_pkg::shift_t w_shift;
  mts_pkg::shift_t m_shift;
  mts_pkg::word_t  w_top;
  mts_pkg::word_t  w_next;
  mts_pkg::word_t  m_top;
  mts_pkg::word_t  m_next;
  mts_pkg::cnt_t   w_count;
  mts_pkg::cnt_t   m_count;
  mts_pkg::word_t  min_after;
  logic            empty_after;

  logic             out_valid_q;
  mts_pkg::word_t   popped_q, popped_d;
  mts_pkg::word_t   min_q, min_d;
  logic             empty_q, empty_d;
  mts_pkg::status_e status_q, status_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_pop     = operation_i == mts_pkg::OpPop;

  assign w_empty = w_count == '0;
  assign w_full  = w_count == mts_pkg::CntW'(mts_pkg::StackDepth);
  assign m_empty = m_count == '0;
  assign m_full  = m_count == mts_pkg::CntW'(mts_pkg::StackDepth);
  assign m_le    = $signed(value_i) <= $signed(m_top);

  assign w_shift.push = accept && !is_pop && !w_full;
  assign w_shift.pop  = accept && is_pop && !w_empty;
  assign m_shift.push = w_shift.push && (m_empty || (!m_full && m_le));
  assign m_shift.pop  = w_shift.pop && !m_empty && (m_top == w_top);

  mts_lifo u_word_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (w_shift),
    .data_i  (value_i),
    .top_o   (w_top),
    .next_o  (w_next),
    .count_o (w_count)
  );

  mts_lifo u_min_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (m_shift),
    .data_i  (value_i),
    .top_o   (m_top),
    .next_o  (m_next),
    .count_o (m_count)
  );

  always_comb begin
    if (m_shift.push) begin
      min_after = value_i;
    end else if (m_shift.pop) begin
      min_after = m_next;
    end else begin
      min_after = m_top;
    end
    if (w_shift.pop) begin
      empty_after = w_count == mts_pkg::CntW'(1);
    end else if (w_shift.push) begin
      empty_after = 1'b0;
    end else begin
      empty_after = w_empty;
    end
    popped_d = w_shift.pop ? w_top : '0;
    min_d    = empty_after ? '0 : min_after;
    empty_d  = empty_after;
    if (is_pop && w_empty) begin
      status_d = mts_pkg::StUnderflow;
    end else if (!is_pop && w_full) begin
      status_d = mts_pkg::StOverflow;
    end else begin
      status_d = mts_pkg::StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      min_q    <= min_d;
      empty_q  <= empty_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = popped_q;
  assign min_value_o    = min_q;
  assign is_empty_o     = empty_q;
  assign status_o       = status_q;

  // unused second word cell only matters for the minimum row
  logic unused_w_next;
  assign unused_w_next = ^w_next;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_count <= mts_pkg::CntW'(mts_pkg::StackDepth))
    else $error("word count above depth");

  a_min_le_words : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_count <= w_count)
    else $error("minimum count above word count");

  a_empty_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_count == '0) == (w_count == '0))
    else $error("minimum row and word row disagree on empty");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_shift.push |=> w_count == $past(w_count) + mts_pkg::CntW'(1))
    else $error("push did not grow the word row");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> empty_q == (w_count == '0))
    else $error("empty flag disagrees with word count");

endmodule
